>>> design/fwrl_pkg.sv
// Shared types and constants for the fixed-window request/token limiter.
// No dependencies; imported by fixed_window_request_token_limiter_unit.
package fwrl_pkg;

  localparam int NUM_CLIENTS = 256;
  localparam int IDX_W       = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int ID_W        = 8;
  localparam int EXT_W       = ID_W + IDX_W;
  localparam int AMOUNT_W    = 24;
  localparam int TIME_W      = 32;
  localparam int REQ_W       = 16;
  localparam int TOK_W       = 32;
  localparam int MAXTOK_W    = 31;
  localparam int INTERVAL_W  = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    ACT_CHECK  = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    VERDICT_ALLOW = 2'd0,
    VERDICT_REQ   = 2'd1,
    VERDICT_TOK   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_MAX_REQ  = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_MAX_TOK  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [REQ_W-1:0]  req;
    logic [TOK_W-1:0]  tok;
  } slot_t;

endpackage

>>> design/fixed_window_request_token_limiter_unit.sv
// Fixed-window per-client request/token limiter, top level.
// Depends on fwrl_pkg.
//
// Usage:
//   Items enter on start/busy: one is transferred at each rising edge with
//   start high and busy low. action selects check (0), record output
//   tokens (1) or clear all slots (2). Every item gives exactly one result,
//   driven on verdict/slot_requests/slot_tokens while done is high for one
//   cycle; the receiver cannot stall, so results never wait.
//   The result goes through the slot memory read and input register, then
//   the registered update pass. Throughput: one item per cycle; a
//   back-to-back item on the same client takes the previous item's written
//   slot through a forwarding register, so no bubbles.
//   Slot state lives in a 256-entry memory with one read and one write port;
//   valid marks are flip-flops, so a clear resets them all at once.
//   Reset (rst, synchronous) clears config and control registers and all
//   valid marks; busy is high only during rst. No clearing sweep is needed.
//   Registers are on the APB port: 0 enable, 4 request limit,
//   8 window length, 12 token limit. Write them only while idle.
module fixed_window_request_token_limiter_unit
  import fwrl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action,
  input  logic                  identified,
  input  logic [ID_W-1:0]       client_id,
  input  logic [AMOUNT_W-1:0]   token_amount,
  input  logic [TIME_W-1:0]     now_seconds,
  output logic                  done,
  output logic [1:0]            verdict,
  output logic [REQ_W-1:0]      slot_requests,
  output logic [TOK_W-1:0]      slot_tokens,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic                  limit_enabled;
  logic [REQ_W-1:0]      req_limit;
  logic [INTERVAL_W-1:0] window_len;
  logic [MAXTOK_W-1:0]   tok_limit;

  logic                  accept;
  logic                  cfg_wr;
  logic [EXT_W-1:0]      id_ext;
  logic [IDX_W-1:0]      in_idx;
  logic                  in_have;

  slot_t                 mem [NUM_CLIENTS];
  slot_t                 rd_data;
  logic [NUM_CLIENTS-1:0] slot_valid;

  logic                  s1_valid;
  action_t               s1_action;
  logic                  s1_have;
  logic [IDX_W-1:0]      s1_idx;
  logic [AMOUNT_W-1:0]   s1_amount;
  logic [TIME_W-1:0]     s1_now;

  logic                  last_we;
  logic [IDX_W-1:0]      last_idx;
  slot_t                 last_data;

  slot_t                 cur;
  slot_t                 new_data;
  logic                  we;
  logic                  set_valid;
  logic                  clear_all;
  logic                  rep_valid;
  verdict_t              verdict_next;

  assign busy   = rst;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign id_ext = {{IDX_W{1'b0}}, client_id};
  assign in_idx = id_ext[IDX_W-1:0];
  assign in_have = identified && (id_ext < EXT_W'(NUM_CLIENTS));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enabled <= 1'b0;
      req_limit     <= '0;
      window_len    <= '0;
      tok_limit     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_ENABLE:   limit_enabled <= pwdata[0];
        REG_MAX_REQ:  req_limit     <= pwdata[REQ_W-1:0];
        REG_INTERVAL: window_len    <= pwdata[INTERVAL_W-1:0];
        REG_MAX_TOK:  tok_limit     <= pwdata[MAXTOK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_ENABLE:   prdata = DATA_W'(limit_enabled);
      REG_MAX_REQ:  prdata = DATA_W'(req_limit);
      REG_INTERVAL: prdata = DATA_W'(window_len);
      REG_MAX_TOK:  prdata = DATA_W'(tok_limit);
      default:      prdata = '0;
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[s1_idx] <= new_data;
    end
    if (accept) begin
      rd_data <= mem[in_idx];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_action <= action_t'(action);
      s1_have   <= in_have;
      s1_idx    <= in_idx;
      s1_amount <= token_amount;
      s1_now    <= now_seconds;
    end
  end

  // update pass
  always_comb begin
    slot_t              fresh;
    slot_t              base;
    slot_t              eff;
    logic               cur_valid;
    logic               active;
    logic [TIME_W-1:0]  elapsed;
    logic [TOK_W:0]     tok_sum;
    logic [TOK_W:0]     rec_sum;
    logic               req_hit;
    logic               tok_hit;

    cur       = (last_we && last_idx == s1_idx) ? last_data : rd_data;
    cur_valid = slot_valid[s1_idx];
    active    = s1_have && limit_enabled && window_len != '0;
    fresh     = '{start: s1_now, req: '0, tok: '0};
    base      = cur_valid ? cur : fresh;
    elapsed   = s1_now - base.start;
    eff       = (elapsed >= TIME_W'(window_len)) ? fresh : base;
    tok_sum   = {1'b0, eff.tok} + (TOK_W+1)'(s1_amount);
    rec_sum   = {1'b0, cur.tok} + (TOK_W+1)'(s1_amount);
    req_hit   = req_limit != '0 && eff.req >= req_limit;
    tok_hit   = tok_limit != '0 && tok_sum > (TOK_W+1)'(tok_limit);

    new_data     = cur;
    we           = 1'b0;
    set_valid    = 1'b0;
    clear_all    = 1'b0;
    rep_valid    = s1_have && cur_valid;
    verdict_next = VERDICT_ALLOW;

    case (s1_action)
      ACT_CHECK: begin
        if (active) begin
          we        = s1_valid;
          set_valid = s1_valid;
          rep_valid = 1'b1;
          new_data  = eff;
          if (req_hit) begin
            verdict_next = VERDICT_REQ;
          end else if (tok_hit) begin
            verdict_next = VERDICT_TOK;
          end else begin
            new_data.req = (eff.req == '1) ? eff.req : eff.req + 1'b1;
            new_data.tok = tok_sum[TOK_W] ? '1 : tok_sum[TOK_W-1:0];
          end
        end
      end
      ACT_RECORD: begin
        if (active && cur_valid) begin
          we           = s1_valid;
          new_data.tok = rec_sum[TOK_W] ? '1 : rec_sum[TOK_W-1:0];
        end
      end
      ACT_CLEAR: begin
        clear_all = s1_valid;
        rep_valid = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      last_we    <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (clear_all) begin
        slot_valid <= '0;
      end else if (set_valid) begin
        slot_valid[s1_idx] <= 1'b1;
      end
      last_we <= we;
      done    <= s1_valid;
    end
    last_idx  <= s1_idx;
    last_data <= new_data;
    if (s1_valid) begin
      verdict       <= verdict_next;
      slot_requests <= rep_valid ? new_data.req : '0;
      slot_tokens   <= rep_valid ? new_data.tok : '0;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without transfer");

  a_throttle_only_check: assert property (@(posedge clk) disable iff (rst)
    (done && verdict != VERDICT_ALLOW) |-> $past(action == ACT_CHECK, 2))
    else $error("throttle verdict on non-check item");

  a_clear_reports_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && action == ACT_CLEAR, 2)) |->
      (verdict == VERDICT_ALLOW && slot_requests == '0 && slot_tokens == '0))
    else $error("clear result not zero");

  a_write_needs_item: assert property (@(posedge clk) disable iff (rst)
    (we || clear_all) |-> s1_valid)
    else $error("slot update with no item in flight");

endmodule
